// ===== hdl/svpwm_pkg.sv =====
// Shared constants for the space vector PWM duty generator.
// Used by the top level, the serial divider and the checker; depends on nothing else.
package svpwm_pkg;

  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned Q15_W      = 16;
  localparam int unsigned X_W        = 33;  // alpha/beta sums, signed
  localparam int unsigned T_W        = 18;  // one active vector time
  localparam int unsigned SUM_W      = T_W + 1;
  localparam int unsigned DVD_W      = T_W + PERIOD_W;
  localparam int unsigned QUO_W      = PERIOD_W;
  localparam int unsigned DIV_STEPS  = QUO_W;

  localparam int unsigned PRE_SHIFT  = 11;
  localparam int unsigned POST_SHIFT = 19;
  localparam int unsigned Q15_SHIFT  = 15;

  localparam logic signed [16:0] ONE_SQRT3_Q15 = 17'sd18919;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4000;

  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;
  localparam logic [2:0] SECTOR_6 = 3'd6;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 88;

endpackage

// ===== hdl/svpwm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the overmodulation scaling.
// Depends on svpwm_pkg for its widths.
module svpwm_div import svpwm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [SUM_W-1:0]  divisor,
  output logic              done,
  output logic [QUO_W-1:0]  quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic [SUM_W-1:0]     rem_r, rem_nxt;
  logic [QUO_W-1:0]     shq_r, shq_nxt;
  logic [SUM_W-1:0]     div_r, div_nxt;
  logic [SUM_W:0]       trial;
  logic [SUM_W:0]       diff;

  // The quotient is known to fit in QUO_W bits, so the upper dividend bits
  // already lie below the divisor and seed the remainder.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    shq_nxt  = shq_r;
    div_nxt  = div_r;
    trial    = {rem_r, shq_r[QUO_W-1]};
    diff     = trial - {1'b0, div_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, dividend[DVD_W-1:QUO_W]};
      shq_nxt  = dividend[QUO_W-1:0];
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[SUM_W-1:0];
        shq_nxt = {shq_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SUM_W-1:0];
        shq_nxt = {shq_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    shq_r <= shq_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = shq_r;

endmodule

// ===== hdl/svpwm_duty_generator.sv =====
// Top level of the six-sector space vector PWM duty generator.
// Depends on svpwm_pkg and instantiates the serial divider svpwm_div.
//
// One (alpha, beta) vector is taken per transfer and one set of three
// centre-aligned compare values comes back. The work on a vector is paced
// by the single shared 22 x 17 bit multiplier, which forms beta/sqrt3 and
// both active times in turn. When the active times exceed the period the
// same multiplier forms both scaled dividends and the one-bit-per-cycle
// divider runs twice. The input is not ready while a vector is in work;
// a finished result waits in an output register, so a new vector can be
// taken before the previous result has been collected. The period register
// is sampled when a vector is taken.
module svpwm_duty_generator import svpwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [PERIOD_W-1:0]   cfg_wr_data,   // pwm_period
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,      // v_alpha, v_beta
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // duty_a, duty_b, duty_c, sector[2:0], overmodulated, overmod_total[31:0], 4 zero bits
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_B1   = 4'd1;
  localparam logic [3:0] S_SECT = 4'd2;
  localparam logic [3:0] S_TF   = 4'd3;
  localparam logic [3:0] S_TS   = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_MF   = 4'd7;
  localparam logic [3:0] S_DF   = 4'd8;
  localparam logic [3:0] S_WF   = 4'd9;
  localparam logic [3:0] S_MS   = 4'd10;
  localparam logic [3:0] S_DS   = 4'd11;
  localparam logic [3:0] S_WS   = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  localparam int unsigned OP_W  = X_W - 1 - PRE_SHIFT;  // clamped operand width
  localparam int unsigned MA_W  = OP_W + 1;
  localparam int unsigned MB_W  = PERIOD_W + 1;
  localparam int unsigned MP_W  = MA_W + MB_W;

  function automatic logic [OP_W-1:0] active_op(input logic signed [X_W-1:0] x);
    logic [OP_W-1:0] r;
    r = x[X_W-1] ? '0 : x[X_W-2:PRE_SHIFT];
    return r;
  endfunction

  logic [3:0]               state_r, state_nxt;
  logic [PERIOD_W-1:0]      period_r;
  logic [PERIOD_W-1:0]      p_r;
  logic signed [Q15_W-1:0]  alpha_r, beta_r;
  logic signed [MP_W-1:0]   mul_r;
  logic [2:0]               sector_r, sector_nxt;
  logic signed [X_W-1:0]    xf_r, xf_nxt, xs_r, xs_nxt;
  logic [T_W-1:0]           tf_r, ts_r;
  logic [SUM_W-1:0]         sum_r;
  logic                     over_r;
  logic [31:0]              total_r;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MP_W-1:0]   mul_p;

  logic signed [X_W-1:0]    a15, b1, nb1, b2, bext;
  logic [SUM_W-1:0]         sum_c;
  logic [SUM_W:0]           tot;
  logic [PERIOD_W-1:0]      lead, d1, d2, v1, v2;
  logic [PERIOD_W-1:0]      duty_a, duty_b, duty_c;
  logic                     div_start, div_done;
  logic [QUO_W-1:0]         div_q;
  logic                     in_xfer, out_free;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_B1: begin
        mul_a = {{(MA_W - Q15_W){beta_r[Q15_W-1]}}, beta_r};
        mul_b = ONE_SQRT3_Q15;
      end
      S_TF: begin
        mul_a = {1'b0, active_op(xf_r)};
        mul_b = {1'b0, p_r};
      end
      S_TS: begin
        mul_a = {1'b0, active_op(xs_r)};
        mul_b = {1'b0, p_r};
      end
      S_MF: begin
        mul_a = {{(MA_W - T_W){1'b0}}, tf_r};
        mul_b = {1'b0, p_r};
      end
      S_MS: begin
        mul_a = {{(MA_W - T_W){1'b0}}, ts_r};
        mul_b = {1'b0, p_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sector and the two active-vector sums, from beta/sqrt3 held in mul_r.
  always_comb begin
    a15  = {{(X_W - Q15_W - Q15_SHIFT){alpha_r[Q15_W-1]}}, alpha_r, {Q15_SHIFT{1'b0}}};
    bext = {{(X_W - Q15_W){beta_r[Q15_W-1]}}, beta_r};
    b1   = mul_r[X_W-1:0];
    nb1  = -b1;
    b2   = (b1 <<< 1) - bext;  // 2/sqrt3 in Q15 is twice 1/sqrt3 less one
    if (!beta_r[Q15_W-1]) begin
      if (!alpha_r[Q15_W-1]) sector_nxt = (b1 >= a15) ? SECTOR_2 : SECTOR_1;
      else                   sector_nxt = (nb1 >= a15) ? SECTOR_3 : SECTOR_2;
    end else begin
      if (!alpha_r[Q15_W-1]) sector_nxt = (nb1 >= a15) ? SECTOR_5 : SECTOR_6;
      else                   sector_nxt = (b1 >= a15) ? SECTOR_4 : SECTOR_5;
    end
    unique case (sector_nxt)
      SECTOR_1: begin xf_nxt = a15 - b1;  xs_nxt = b2;        end
      SECTOR_2: begin xf_nxt = a15 + b1;  xs_nxt = b1 - a15;  end
      SECTOR_3: begin xf_nxt = b2;        xs_nxt = nb1 - a15; end
      SECTOR_4: begin xf_nxt = b1 - a15;  xs_nxt = -b2;       end
      SECTOR_5: begin xf_nxt = nb1 - a15; xs_nxt = a15 - b1;  end
      default:  begin xf_nxt = -b2;       xs_nxt = a15 + b1;  end
    endcase
  end

  // Centre-aligned compares from the final active times.
  always_comb begin
    sum_c = {1'b0, tf_r} + {1'b0, ts_r};
    tot   = {{(SUM_W + 1 - PERIOD_W){1'b0}}, p_r} + {2'b0, tf_r} + {2'b0, ts_r};
    lead  = tot[PERIOD_W:1];
    if (sector_r[0]) begin
      d1 = tf_r[PERIOD_W-1:0];
      d2 = ts_r[PERIOD_W-1:0];
    end else begin
      d1 = ts_r[PERIOD_W-1:0];
      d2 = tf_r[PERIOD_W-1:0];
    end
    v1 = lead - d1;
    v2 = v1 - d2;
    unique case (sector_r)
      SECTOR_1: begin duty_a = lead; duty_b = v1;   duty_c = v2;   end
      SECTOR_2: begin duty_a = v1;   duty_b = lead; duty_c = v2;   end
      SECTOR_3: begin duty_a = v2;   duty_b = lead; duty_c = v1;   end
      SECTOR_4: begin duty_a = v2;   duty_b = v1;   duty_c = lead; end
      SECTOR_5: begin duty_a = v1;   duty_b = v2;   duty_c = lead; end
      default:  begin duty_a = lead; duty_b = v2;   duty_c = v1;   end
    endcase
  end

  assign div_start = (state_r == S_DF) || (state_r == S_DS);

  svpwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_r[DVD_W-1:0]),
    .divisor  (sum_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_B1;
      S_B1:   state_nxt = S_SECT;
      S_SECT: state_nxt = S_TF;
      S_TF:   state_nxt = S_TS;
      S_TS:   state_nxt = S_SUM;
      S_SUM:  state_nxt = S_CHK;
      S_CHK:  state_nxt = (sum_c > {{(SUM_W - PERIOD_W){1'b0}}, p_r}) ? S_MF : S_FIN;
      S_MF:   state_nxt = S_DF;
      S_DF:   state_nxt = S_WF;
      S_WF:   if (div_done) state_nxt = S_MS;
      S_MS:   state_nxt = S_DS;
      S_DS:   state_nxt = S_WS;
      S_WS:   if (div_done) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RESET;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) period_r <= cfg_wr_data;
      if (state_r == S_CHK && state_nxt == S_MF) total_r <= total_r + 32'd1;
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_tready)              out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_p;
    if (in_xfer) begin
      alpha_r <= in_tdata[Q15_W-1:0];
      beta_r  <= in_tdata[2*Q15_W-1:Q15_W];
      p_r     <= period_r;
    end
    if (state_r == S_SECT) begin
      sector_r <= sector_nxt;
      xf_r     <= xf_nxt;
      xs_r     <= xs_nxt;
    end
    if (state_r == S_TS) tf_r <= mul_r[POST_SHIFT +: T_W];
    if (state_r == S_SUM) ts_r <= mul_r[POST_SHIFT +: T_W];
    if (state_r == S_CHK) begin
      sum_r  <= sum_c;
      over_r <= (state_nxt == S_MF);
    end
    if (state_r == S_WF && div_done) tf_r <= {{(T_W - QUO_W){1'b0}}, div_q};
    if (state_r == S_WS && div_done) ts_r <= {{(T_W - QUO_W){1'b0}}, div_q};
    if (state_r == S_FIN && out_free)
      out_data_r <= {4'b0, total_r, over_r, sector_r, duty_c, duty_b, duty_a};
  end

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/svpwm_chk.sv =====
// Port-level checker for the duty generator, attached by the bind below.
// Depends on svpwm_pkg for the channel widths.
module svpwm_chk import svpwm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [31:0] prev_total_r;
  logic [2:0]  sec;

  assign sec = out_tdata[50:48];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_total_r <= '0;
    end else if (out_tvalid && out_tready) begin
      prev_total_r <= out_tdata[83:52];
    end
  end

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_sector: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (sec == SECTOR_1 || sec == SECTOR_2 || sec == SECTOR_3 ||
                    sec == SECTOR_4 || sec == SECTOR_5 || sec == SECTOR_6))
    else $error("sector out of range");

  // The running count advances by exactly the overmodulation flag per result.
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> out_tdata[83:52] == prev_total_r + 32'(out_tdata[51]))
    else $error("overmodulation count inconsistent");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready straight after a transfer");

endmodule

bind svpwm_duty_generator svpwm_chk u_svpwm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
